FILE: hdl/tsa_pkg.sv
package tsa_pkg;

  localparam int unsigned StackSlots = 256;
  localparam int unsigned PtrW = $clog2(StackSlots);
  localparam int unsigned CntW = $clog2(StackSlots + 1);

  localparam logic [7:0] TagUint = 8'h04;
  localparam logic [7:0] TagInt  = 8'h02;
  localparam logic [7:0] TagBool = 8'h06;
  localparam logic [7:0] TagByte = 8'h03;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StDiv0  = 2'd1;
  localparam logic [1:0] StUnder = 2'd2;
  localparam logic [1:0] StOver  = 2'd3;

  localparam logic [5:0] ActUAdd = 6'd0;
  localparam logic [5:0] ActUSub = 6'd1;
  localparam logic [5:0] ActUMul = 6'd2;
  localparam logic [5:0] ActUDiv = 6'd3;
  localparam logic [5:0] ActUMod = 6'd4;
  localparam logic [5:0] ActSAdd = 6'd5;
  localparam logic [5:0] ActSSub = 6'd6;
  localparam logic [5:0] ActSMul = 6'd7;
  localparam logic [5:0] ActSDiv = 6'd8;
  localparam logic [5:0] ActSMod = 6'd9;
  localparam logic [5:0] ActULt  = 6'd10;
  localparam logic [5:0] ActULe  = 6'd11;
  localparam logic [5:0] ActUGt  = 6'd12;
  localparam logic [5:0] ActUGe  = 6'd13;
  localparam logic [5:0] ActSLt  = 6'd14;
  localparam logic [5:0] ActSLe  = 6'd15;
  localparam logic [5:0] ActSGt  = 6'd16;
  localparam logic [5:0] ActSGe  = 6'd17;
  localparam logic [5:0] ActEq   = 6'd18;
  localparam logic [5:0] ActNe   = 6'd19;
  localparam logic [5:0] ActBAnd = 6'd20;
  localparam logic [5:0] ActBOr  = 6'd21;
  localparam logic [5:0] ActBNot = 6'd22;
  localparam logic [5:0] ActAnd  = 6'd23;
  localparam logic [5:0] ActOr   = 6'd24;
  localparam logic [5:0] ActXor  = 6'd25;
  localparam logic [5:0] ActNot  = 6'd26;
  localparam logic [5:0] ActShl  = 6'd27;
  localparam logic [5:0] ActShr  = 6'd28;
  localparam logic [5:0] ActPsh0 = 6'd29;
  localparam logic [5:0] ActPsh1 = 6'd30;
  localparam logic [5:0] ActPshI = 6'd31;
  localparam logic [5:0] ActPsh2 = 6'd32;
  localparam logic [5:0] ActAddI = 6'd33;
  localparam logic [5:0] ActSubI = 6'd34;
  localparam logic [5:0] ActCast = 6'd35;
  localparam logic [5:0] ActLeI  = 6'd36;

  typedef struct packed {
    logic [5:0] action;
    logic [7:0] imm_first;
    logic [7:0] imm_second;
  } in_item_t;

  typedef struct packed {
    logic [15:0] top_value;
    logic [7:0]  top_type;
    logic [8:0]  stack_depth;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_PUSH2, S_RDTOP, S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch input item
    logic rd_ops;    // read top and next
    logic exec;      // compute and commit
    logic div_step;  // one divider iteration
    logic div_done;  // commit divider result
    logic push2;     // second push of two-byte push
    logic rd_top;    // read new top for output
    logic fin;       // capture output
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_div;
    logic div0;
    logic div_last;
    logic two_push;
  } stat_t;

endpackage

FILE: hdl/typed_stack_alu_core.sv
// Typed stack ALU core: one stack operation per item, one result item back.
// Each item is read, executed and, for divide/modulo by a nonzero divisor,
// run through a 16-step restoring divider (a two-byte push instead writes
// its second byte); the new top is then read back into the result item.
// One item at a time: the next item is taken once the result is delivered.
// Async active-low reset empties the stack; the stack RAM itself is not cleared.
module typed_stack_alu_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tsa_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tsa_pkg::out_item_t  out_item_o
);

  tsa_pkg::ctrl_t ctrl;
  tsa_pkg::stat_t stat;

  // sequencer: read, execute, optional divide loop / second push, readback
  tsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // stack memory, ALU, divider and result register
  tsa_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

FILE: hdl/tsa_ctrl.sv
module tsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  tsa_pkg::stat_t  stat_i,
  output tsa_pkg::ctrl_t  ctrl_o
);

  tsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsa_pkg::S_IDLE:  if (in_valid_i) state_d = tsa_pkg::S_READ;
      tsa_pkg::S_READ:  state_d = tsa_pkg::S_EXEC;
      tsa_pkg::S_EXEC: begin
        if (stat_i.is_div && !stat_i.div0) state_d = tsa_pkg::S_DIV;
        else if (stat_i.two_push) state_d = tsa_pkg::S_PUSH2;
        else state_d = tsa_pkg::S_RDTOP;
      end
      tsa_pkg::S_DIV:   if (stat_i.div_last) state_d = tsa_pkg::S_RDTOP;
      tsa_pkg::S_PUSH2: state_d = tsa_pkg::S_RDTOP;
      tsa_pkg::S_RDTOP: state_d = tsa_pkg::S_OUT;
      tsa_pkg::S_OUT:   if (out_ready_i) state_d = tsa_pkg::S_IDLE;
      default:          state_d = tsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      tsa_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      tsa_pkg::S_READ:  ctrl_o.rd_ops = 1'b1;
      tsa_pkg::S_EXEC:  ctrl_o.exec = 1'b1;
      tsa_pkg::S_DIV: begin
        ctrl_o.div_step = 1'b1;
        ctrl_o.div_done = stat_i.div_last;
      end
      tsa_pkg::S_PUSH2: ctrl_o.push2 = 1'b1;
      tsa_pkg::S_RDTOP: ctrl_o.rd_top = 1'b1;
      tsa_pkg::S_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
    ctrl_o.fin = (state_q == tsa_pkg::S_RDTOP);
  end

endmodule

FILE: hdl/tsa_dpath.sv
module tsa_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsa_pkg::in_item_t   in_item_i,
  input  tsa_pkg::ctrl_t      ctrl_i,
  output tsa_pkg::stat_t      stat_o,
  output tsa_pkg::out_item_t  out_item_o
);

  localparam int unsigned PW = tsa_pkg::PtrW;
  localparam int unsigned CW = tsa_pkg::CntW;

  logic [15:0] val_mem [tsa_pkg::StackSlots];
  logic [7:0]  tag_mem [tsa_pkg::StackSlots];

  tsa_pkg::in_item_t item_q;
  logic [CW-1:0] cnt_q;
  logic [15:0] a_q, b_q, rdv_q;
  logic [7:0]  rdt_q;
  logic [1:0]  st_q;
  tsa_pkg::out_item_t out_q;

  // divider
  logic [15:0] dq_q, dr_q, dd_q;
  logic [4:0]  dn_q;
  logic        dneg_q, rneg_q;

  logic [5:0] act;
  assign act = item_q.action;

  logic [1:0] need;
  logic [1:0] room;
  always_comb begin
    need = 2'd0;
    room = 2'd0;
    case (act) inside
      [tsa_pkg::ActUAdd:tsa_pkg::ActBOr], [tsa_pkg::ActAnd:tsa_pkg::ActXor],
      tsa_pkg::ActShl, tsa_pkg::ActShr: need = 2'd2;
      tsa_pkg::ActBNot, tsa_pkg::ActNot,
      [tsa_pkg::ActAddI:tsa_pkg::ActLeI]: need = 2'd1;
      [tsa_pkg::ActPsh0:tsa_pkg::ActPshI]: room = 2'd1;
      tsa_pkg::ActPsh2: room = 2'd2;
      default: ;
    endcase
  end

  logic [CW:0] room_sum;
  assign room_sum = {1'b0, cnt_q} + {{(CW-1){1'b0}}, room};

  logic under, over, valid_act;
  assign valid_act = (act <= tsa_pkg::ActLeI);
  assign under = valid_act && (cnt_q < {{(CW-2){1'b0}}, need});
  assign over  = valid_act && !under && (room != 2'd0) &&
                 (room_sum > (CW+1)'(tsa_pkg::StackSlots));

  logic go;
  assign go = valid_act && !under && !over;

  logic is_div;
  assign is_div = (act == tsa_pkg::ActUDiv) || (act == tsa_pkg::ActUMod) ||
                  (act == tsa_pkg::ActSDiv) || (act == tsa_pkg::ActSMod);
  logic sgn_div;
  assign sgn_div = (act == tsa_pkg::ActSDiv) || (act == tsa_pkg::ActSMod);

  assign stat_o.is_div   = go && is_div && (need == 2'd2);
  assign stat_o.div0     = (b_q == 16'd0);
  assign stat_o.div_last = (dn_q == 5'd15);
  assign stat_o.two_push = go && (act == tsa_pkg::ActPsh2);

  // binary ALU
  logic [15:0] r2;
  logic [7:0]  t2;
  logic signed [15:0] sa, sb;
  logic [31:0] prod;
  logic [15:0] shl, shr;
  assign sa = a_q;
  assign sb = b_q;
  assign prod = a_q * b_q;
  assign shl = (b_q >= 16'd16) ? 16'd0 : (a_q << b_q[3:0]);
  assign shr = (b_q >= 16'd16) ? 16'd0 : (a_q >> b_q[3:0]);

  always_comb begin
    r2 = 16'd0;
    t2 = tsa_pkg::TagUint;
    case (act)
      tsa_pkg::ActUAdd: r2 = a_q + b_q;
      tsa_pkg::ActUSub: r2 = a_q - b_q;
      tsa_pkg::ActUMul: r2 = prod[15:0];
      tsa_pkg::ActSAdd: begin r2 = a_q + b_q; t2 = tsa_pkg::TagInt; end
      tsa_pkg::ActSSub: begin r2 = a_q - b_q; t2 = tsa_pkg::TagInt; end
      tsa_pkg::ActSMul: begin r2 = prod[15:0]; t2 = tsa_pkg::TagInt; end
      tsa_pkg::ActULt: begin r2 = {15'd0, a_q < b_q};  t2 = tsa_pkg::TagBool; end
      tsa_pkg::ActULe: begin r2 = {15'd0, a_q <= b_q}; t2 = tsa_pkg::TagBool; end
      tsa_pkg::ActUGt: begin r2 = {15'd0, a_q > b_q};  t2 = tsa_pkg::TagBool; end
      tsa_pkg::ActUGe: begin r2 = {15'd0, a_q >= b_q}; t2 = tsa_pkg::TagBool; end
      tsa_pkg::ActSLt: begin r2 = {15'd0, sa < sb};  t2 = tsa_pkg::TagBool; end
      tsa_pkg::ActSLe: begin r2 = {15'd0, sa <= sb}; t2 = tsa_pkg::TagBool; end
      tsa_pkg::ActSGt: begin r2 = {15'd0, sa > sb};  t2 = tsa_pkg::TagBool; end
      tsa_pkg::ActSGe: begin r2 = {15'd0, sa >= sb}; t2 = tsa_pkg::TagBool; end
      tsa_pkg::ActEq:  begin r2 = {15'd0, a_q == b_q}; t2 = tsa_pkg::TagBool; end
      tsa_pkg::ActNe:  begin r2 = {15'd0, a_q != b_q}; t2 = tsa_pkg::TagBool; end
      tsa_pkg::ActBAnd: begin
        r2 = {15'd0, (a_q != 16'd0) && (b_q != 16'd0)}; t2 = tsa_pkg::TagBool;
      end
      tsa_pkg::ActBOr: begin
        r2 = {15'd0, (a_q != 16'd0) || (b_q != 16'd0)}; t2 = tsa_pkg::TagBool;
      end
      tsa_pkg::ActAnd: r2 = a_q & b_q;
      tsa_pkg::ActOr:  r2 = a_q | b_q;
      tsa_pkg::ActXor: r2 = a_q ^ b_q;
      tsa_pkg::ActShl: r2 = shl;
      default:         r2 = shr;
    endcase
  end

  // unary ALU on top (b_q holds top value, rdt_q its tag)
  logic [15:0] r1;
  logic [7:0]  t1;
  logic [15:0] imm16;
  assign imm16 = {8'd0, item_q.imm_first};
  always_comb begin
    r1 = b_q;
    t1 = rdt_q;
    case (act)
      tsa_pkg::ActBNot: begin r1 = {15'd0, b_q == 16'd0}; t1 = tsa_pkg::TagBool; end
      tsa_pkg::ActNot:  begin r1 = ~b_q; t1 = tsa_pkg::TagUint; end
      tsa_pkg::ActAddI: begin r1 = b_q + imm16; t1 = tsa_pkg::TagUint; end
      tsa_pkg::ActSubI: begin r1 = b_q - imm16; t1 = tsa_pkg::TagUint; end
      tsa_pkg::ActCast: t1 = item_q.imm_first;
      default: begin r1 = {15'd0, b_q <= imm16}; t1 = tsa_pkg::TagBool; end
    endcase
  end

  logic [15:0] pv;
  always_comb begin
    case (act)
      tsa_pkg::ActPsh0: pv = 16'd0;
      tsa_pkg::ActPsh1: pv = 16'd1;
      default:          pv = imm16;
    endcase
  end

  // divider step (restoring, magnitudes)
  logic [16:0] dtrial;
  logic [15:0] dq_n, dr_n, dd_n;
  assign dtrial = {dr_q, dq_q[15]} - {1'b0, dd_q};
  assign dq_n = {dq_q[14:0], ~dtrial[16]};
  assign dr_n = dtrial[16] ? {dr_q[14:0], dq_q[15]} : dtrial[15:0];
  assign dd_n = dd_q;

  logic [15:0] qfin, rfin, dres;
  assign qfin = dneg_q ? (16'd0 - dq_n) : dq_n;
  assign rfin = rneg_q ? (16'd0 - dr_n) : dr_n;
  assign dres = ((act == tsa_pkg::ActUDiv) || (act == tsa_pkg::ActSDiv)) ? qfin : rfin;

  logic [PW-1:0] ptop, pnext;
  assign ptop  = PW'(cnt_q - CW'(1));
  assign pnext = PW'(cnt_q - CW'(2));

  logic          we;
  logic [PW-1:0] wa;
  logic [15:0]   wv;
  logic [7:0]    wt;
  always_comb begin
    we = 1'b0;
    wa = ptop;
    wv = r2;
    wt = t2;
    if (ctrl_i.exec && go) begin
      if (need == 2'd2) begin
        we = !is_div;
        wa = pnext;
      end else if (need == 2'd1) begin
        we = 1'b1;
        wv = r1;
        wt = t1;
      end else begin
        we = 1'b1;
        wa = PW'(cnt_q);
        wv = pv;
        wt = tsa_pkg::TagByte;
      end
    end else if (ctrl_i.div_done) begin
      we = 1'b1;
      wa = pnext;
      wv = dres;
      wt = sgn_div ? tsa_pkg::TagInt : tsa_pkg::TagUint;
    end else if (ctrl_i.push2) begin
      we = 1'b1;
      wa = PW'(cnt_q);
      wv = {8'd0, item_q.imm_second};
      wt = tsa_pkg::TagByte;
    end
  end

  logic [PW-1:0] ra;
  assign ra = ctrl_i.rd_top ? ptop : pnext;

  always_ff @(posedge clk_i) begin
    if (we) begin
      val_mem[wa] <= wv;
      tag_mem[wa] <= wt;
    end
    if (ctrl_i.rd_ops || ctrl_i.rd_top) begin
      rdv_q <= val_mem[ra];
    end
    if (ctrl_i.rd_ops || ctrl_i.rd_top) begin
      rdt_q <= tag_mem[ctrl_i.rd_top ? ptop : ptop];
    end
  end

  // second read port: top value for operands
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_ops) begin
      b_q <= val_mem[ptop];
    end
  end
  assign a_q = rdv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      st_q  <= tsa_pkg::StOk;
    end else begin
      if (ctrl_i.exec) begin
        st_q <= under ? tsa_pkg::StUnder : over ? tsa_pkg::StOver :
                (go && is_div && need == 2'd2 && b_q == 16'd0) ? tsa_pkg::StDiv0 :
                tsa_pkg::StOk;
        if (go) begin
          if (need == 2'd2) begin
            if (!is_div) cnt_q <= cnt_q - CW'(1);
            else if (b_q == 16'd0) cnt_q <= cnt_q - CW'(2);
          end else if (need == 2'd0) begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
      end
      if (ctrl_i.div_done || ctrl_i.push2) begin
        cnt_q <= ctrl_i.push2 ? cnt_q + CW'(1) : cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      item_q <= in_item_i;
    end
    if (ctrl_i.exec) begin
      dq_q   <= (sgn_div && a_q[15]) ? 16'd0 - a_q : a_q;
      dd_q   <= (sgn_div && b_q[15]) ? 16'd0 - b_q : b_q;
      dr_q   <= 16'd0;
      dn_q   <= 5'd0;
      dneg_q <= sgn_div && (a_q[15] ^ b_q[15]);
      rneg_q <= sgn_div && a_q[15];
    end else if (ctrl_i.div_step) begin
      dq_q <= dq_n;
      dr_q <= dr_n;
      dd_q <= dd_n;
      dn_q <= dn_q + 5'd1;
    end
    if (ctrl_i.fin) begin
      out_q.top_value   <= (cnt_q == '0) ? 16'd0 : val_mem[ptop];
      out_q.top_type    <= (cnt_q == '0) ? 8'd0 : tag_mem[ptop];
      out_q.stack_depth <= 9'(cnt_q);
      out_q.status      <= st_q;
    end
  end

  assign out_item_o = out_q;

endmodule
